FILE: hdl/vfce_pkg.sv
// ----------------------------------------------------------------------------
// vfce_pkg: shared types and constants
// Widths, fixed-point constants and the per-point control bundle used by the
// surface elevation integrator.
// ----------------------------------------------------------------------------
package vfce_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 17;
  localparam int unsigned TolW   = 16;
  localparam int unsigned DxW    = CoordW + 1;
  localparam int unsigned FsumW  = FracW + 1;
  localparam int unsigned TermW  = DxW + FsumW + 1;
  localparam int unsigned AreaW  = 64;
  localparam int unsigned InDataW = 56;

  localparam logic [FracW-1:0]        FracOne   = 17'd65536;
  localparam logic [TolW-1:0]         TolReset  = 16'd7;
  localparam logic signed [AreaW-1:0] AreaLimit = 64'sd4611686018427387904;
  localparam logic signed [AreaW-1:0] AreaRound = 64'sd65536;
  localparam logic [CoordW-1:0]       ElevMin   = 32'h8000_0000;
  localparam logic [CoordW-1:0]       ElevMax   = 32'h7fff_ffff;

  // Line position of one point, carried alongside its data
  typedef struct packed {
    logic first;  // opens a new line
    logic multi;  // at least two points in the line, this one included
    logic last;   // closes the line
  } pt_ctl_t;

endpackage

FILE: hdl/vfce_term.sv
// ----------------------------------------------------------------------------
// vfce_term: input register and trapezoid term
// Registers each point with its difference to the previous point, then forms
// dx * (f + f_prev) in a second register stage.
// ----------------------------------------------------------------------------
module vfce_term
  import vfce_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [InDataW-1:0]       in_tdata,
  input  logic                     in_tlast,
  input  logic                     dn_ready,
  output logic                     pt_valid,
  output logic signed [TermW-1:0]  pt_term,
  output logic signed [CoordW-1:0] pt_coord,
  output logic [FracW-1:0]         pt_frac,
  output pt_ctl_t                  pt_ctl
);

  logic                     v0_r, v1_r;
  logic                     rdy0, rdy1, acc;
  logic [1:0]               pts_r, pts_nxt;
  logic signed [CoordW-1:0] prev_c_r;
  logic [FracW-1:0]         prev_f_r;
  logic signed [CoordW-1:0] c_in;
  logic [FracW-1:0]         f_raw, f_in;
  logic signed [DxW-1:0]    dx_r, dx_nxt;
  logic [FsumW-1:0]         fsum_r, fsum_nxt;
  logic signed [CoordW-1:0] c0_r, c1_r;
  logic [FracW-1:0]         f0_r, f1_r;
  pt_ctl_t                  ctl0_r, ctl1_r, ctl_nxt;
  logic signed [TermW-1:0]  term_r, term_nxt;

  assign c_in  = $signed(in_tdata[CoordW-1:0]);
  assign f_raw = in_tdata[CoordW+FracW-1:CoordW];
  assign f_in  = (f_raw > FracOne) ? FracOne : f_raw;

  assign rdy1      = !v1_r || dn_ready;
  assign rdy0      = !v0_r || rdy1;
  assign in_tready = rdy0;
  assign acc       = in_tvalid && rdy0;

  always_comb begin
    dx_nxt        = {c_in[CoordW-1], c_in} - {prev_c_r[CoordW-1], prev_c_r};
    fsum_nxt      = {1'b0, f_in} + {1'b0, prev_f_r};
    ctl_nxt.first = (pts_r == 2'd0);
    ctl_nxt.multi = (pts_r != 2'd0);
    ctl_nxt.last  = in_tlast;
    // count points, saturate at two, restart after the closing point
    if (in_tlast) begin
      pts_nxt = 2'd0;
    end else if (pts_r == 2'd2) begin
      pts_nxt = pts_r;
    end else begin
      pts_nxt = pts_r + 2'd1;
    end
    term_nxt = dx_r * $signed({1'b0, fsum_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      pts_r <= 2'd0;
    end else begin
      if (rdy0) begin
        v0_r <= in_tvalid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (acc) begin
        pts_r <= pts_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_c_r <= c_in;
      prev_f_r <= f_in;
      dx_r     <= dx_nxt;
      fsum_r   <= fsum_nxt;
      c0_r     <= c_in;
      f0_r     <= f_in;
      ctl0_r   <= ctl_nxt;
    end
    if (rdy1 && v0_r) begin
      term_r <= term_nxt;
      c1_r   <= c0_r;
      f1_r   <= f0_r;
      ctl1_r <= ctl0_r;
    end
  end

  assign pt_valid = v1_r;
  assign pt_term  = term_r;
  assign pt_coord = c1_r;
  assign pt_frac  = f1_r;
  assign pt_ctl   = ctl1_r;

endmodule

FILE: hdl/volume_fraction_column_elevation.sv
// ----------------------------------------------------------------------------
// volume_fraction_column_elevation: surface elevation of one sampling line
// Integrates liquid fraction along a line by the trapezoidal rule and emits
// min coordinate plus half the area on the closing point of each line.
// ----------------------------------------------------------------------------
// Points enter one per cycle at full rate through a four-register pipeline:
// input register, multiply, accumulate, output rounding. The accumulate and
// min compare feed back within their own stage, so throughput is one point
// per clock while out_tready stays high. The user must write the tolerance
// register only while the block is idle; the block does not enforce this.
// cfg_ready is always high.
module volume_fraction_column_elevation
  import vfce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TolW-1:0]    cfg_data,    // fraction_tolerance
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [InDataW-1:0] in_tdata,    // [31:0] coord_value, [48:32] fraction_value
  input  logic               in_tlast,    // last_point
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [CoordW-1:0]  out_tdata,   // [31:0] elevation
  output logic [0:0]         out_tuser    // [0] valid_res
);

  logic [TolW-1:0]          tol_r;
  logic                     pt_valid;
  logic signed [TermW-1:0]  pt_term;
  logic signed [CoordW-1:0] pt_coord;
  logic [FracW-1:0]         pt_frac;
  pt_ctl_t                  pt_ctl;
  logic                     rdy2, rdy3, adv1;

  logic signed [AreaW-1:0]  area_r, area_nxt, area_sum;
  logic signed [CoordW-1:0] min_r, min_nxt;
  logic [FracW-1:0]         ff_r, ff_nxt;
  logic [FracW-1:0]         wet_thr;
  logic                     ok_nxt;

  logic                     v2_r, ok2_r;
  logic signed [AreaW-1:0]  area2_r;
  logic signed [CoordW-1:0] min2_r;

  logic                     v3_r, ok3_r;
  logic [CoordW-1:0]        elev_r, elev_nxt;
  logic signed [AreaW-1:0]  rnd;
  logic signed [AreaW-18:0] half;
  logic signed [AreaW-17:0] esum;

  assign cfg_ready = 1'b1;

  vfce_term u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .dn_ready  (rdy2),
    .pt_valid  (pt_valid),
    .pt_term   (pt_term),
    .pt_coord  (pt_coord),
    .pt_frac   (pt_frac),
    .pt_ctl    (pt_ctl)
  );

  assign rdy3 = !v3_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign adv1 = pt_valid && rdy2;

  // accumulate stage
  always_comb begin
    area_sum = area_r + AreaW'(pt_term);
    wet_thr  = FracOne - {1'b0, tol_r};
    if (pt_ctl.first) begin
      area_nxt = '0;
      min_nxt  = pt_coord;
      ff_nxt   = pt_frac;
    end else begin
      priority if (area_sum > AreaLimit) begin
        area_nxt = AreaLimit;
      end else if (area_sum < -AreaLimit) begin
        area_nxt = -AreaLimit;
      end else begin
        area_nxt = area_sum;
      end
      min_nxt = (pt_coord < min_r) ? pt_coord : min_r;
      ff_nxt  = ff_r;
    end
    // mark single-point lines and lines whose ends are both dry or both wet invalid
    ok_nxt = pt_ctl.multi
          && !((ff_nxt < {1'b0, tol_r}) && (pt_frac < {1'b0, tol_r}))
          && !((ff_nxt > wet_thr) && (pt_frac > wet_thr));
  end

  // output stage: min + floor((area + 2^16) / 2^17), saturated
  always_comb begin
    rnd  = area2_r + AreaRound;
    half = rnd[AreaW-1:17];
    esum = (AreaW-16)'(min2_r) + (AreaW-16)'(half);
    priority if (!ok2_r) begin
      elev_nxt = ElevMin;
    end else if (esum > $signed((AreaW-16)'($signed(ElevMax)))) begin
      elev_nxt = ElevMax;
    end else if (esum < $signed((AreaW-16)'($signed(ElevMin)))) begin
      elev_nxt = ElevMin;
    end else begin
      elev_nxt = esum[CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r  <= TolReset;
      area_r <= '0;
      min_r  <= '0;
      ff_r   <= '0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
      if (adv1) begin
        area_r <= area_nxt;
        min_r  <= min_nxt;
        ff_r   <= ff_nxt;
      end
      if (rdy2) begin
        v2_r <= pt_valid && pt_ctl.last;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && pt_ctl.last) begin
      area2_r <= area_nxt;
      min2_r  <= min_nxt;
      ok2_r   <= ok_nxt;
    end
    if (rdy3 && v2_r) begin
      elev_r <= elev_nxt;
      ok3_r  <= ok2_r;
    end
  end

  assign out_tvalid   = v3_r;
  assign out_tdata    = elev_r;
  assign out_tuser[0] = ok3_r;

`ifndef ASSERT_OFF
  a_area_range: assert property (@(posedge clk) disable iff (!rst_n)
    (area_r <= AreaLimit) && (area_r >= -AreaLimit))
    else $error("accumulator outside saturation limits");

  a_invalid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == ElevMin)
    else $error("invalid result without the invalid elevation code");

  a_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    rdy2 && pt_valid && !pt_ctl.last |=> !v2_r)
    else $error("result stage loaded by a point that does not close a line");
`endif

endmodule
